>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the prime search block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define PSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psd checker: property violated");

// Clocked property, checked on every edge, reset included.
`define PSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("psd checker: property violated");

`endif

>>> src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types, status codes and constants of the prime search block.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int DIGIT_W  = 4;
  localparam int PRIME_W  = 16;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic [DIGIT_W-1:0]  digit_t;
  typedef logic [PRIME_W-1:0]  prime_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_REJECT    = 2'd1;
  localparam status_t ST_EXHAUSTED = 2'd2;
  localparam status_t ST_LIMIT     = 2'd3;

  localparam count_t PRIME_COUNT_RST = 7'd10;
  localparam digit_t DIGIT_MAX       = 4'd9;
  localparam digit_t DIGIT_FIVE      = 4'd5;
  localparam int     CAND_STEP       = 10;
  localparam int     FIRST_DIVISOR   = 2;

  // Status returned by the shared remainder unit.
  typedef struct packed {
    logic done;
    logic is_zero;
  } rem_stat_t;

endpackage

>>> src/psd_if.sv
// ----------------------------------------------------------------------------
// psd_in_if / psd_out_if
// Valid/ready channels of the prime search block.
// ----------------------------------------------------------------------------
interface psd_in_if;
  logic             valid;
  logic             ready;
  psd_pkg::digit_t  last_digit;

  modport source (output valid, output last_digit, input ready);
  modport sink   (input valid, input last_digit, output ready);
endinterface

interface psd_out_if;
  logic             valid;
  logic             ready;
  psd_pkg::prime_t  prime_value;
  psd_pkg::pos_t    position;
  logic             last_of_run;
  psd_pkg::status_t status;

  modport source (output valid, output prime_value, output position,
                  output last_of_run, output status, input ready);
  modport sink   (input valid, input prime_value, input position,
                  input last_of_run, input status, output ready);
endinterface

>>> src/psd_rem.sv
// ----------------------------------------------------------------------------
// psd_rem
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module psd_rem #(
  parameter int NUM_W = 16,
  parameter int DIV_W = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [DIV_W-1:0]     div,
  output psd_pkg::rem_stat_t   stat
);
  import psd_pkg::*;

  localparam int CntW = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;

  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;
  logic [DIV_W-1:0]  rem_step;

  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]};
    diff     = trial - {1'b0, div};
    fits     = (trial >= {1'b0, div});
    rem_step = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(NUM_W);
      num_nxt  = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      num_nxt = num_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done    = done_r;
  assign stat.is_zero = (rem_r == '0);

endmodule

>>> src/prime_search_by_last_digit.sv
// ----------------------------------------------------------------------------
// prime_search_by_last_digit
// Emits the first N primes ending in a requested decimal digit, found by
// trial division on a shared iterative remainder unit.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+--------------------------------------
//   in_ch    | in  | valid/ready       | last_digit
//   out_ch   | out | valid/ready       | prime_value, position, last_of_run,
//            |     |                   | status
//   cfg_*    | in  | cfg_wr_en strobe  | cfg_wr_data = prime_count
//
// Steps: a candidate passes S_CAND, then S_DCHK and S_DIV for each trial divisor
//   tried (2 up to its first factor or floor(sqrt(n))), then S_EMIT if prime.
// in_ch.ready is high only between runs; one request is worked at a time.
// Reset (synchronous, rst_n low) returns to idle, empties the output register
//   and loads prime_count with 10; no clearing pass is needed.
// A stalled out_ch holds the sequencer at its next result until it drains.
// ----------------------------------------------------------------------------
module prime_search_by_last_digit #(
  parameter int MAX_COUNT   = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  psd_pkg::count_t   cfg_wr_data,
  psd_in_if.sink            in_ch,
  psd_out_if.source         out_ch
);
  import psd_pkg::*;

  // Candidate carries one extra bit so that stepping past the limit shows.
  localparam int CandW = VALUE_WIDTH + 1;
  // Trial divisor reaches floor(sqrt(limit)) + 1.
  localparam int DivW  = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SqW   = VALUE_WIDTH + 2;
  localparam count_t MaxCnt = count_t'(MAX_COUNT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CAND = 3'd1;
  localparam logic [2:0] S_DCHK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  count_t            cfg_r, cfg_nxt;
  logic              five_r, five_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CandW-1:0]  cand_r, cand_nxt;
  logic [DivW-1:0]   d_r, d_nxt;
  logic [SqW-1:0]    sq_r, sq_nxt;
  count_t            found_r, found_nxt;
  count_t            want_r, want_nxt;

  // Pending result, waiting for the output register.
  prime_t            res_value_r, res_value_nxt;
  pos_t              res_pos_r, res_pos_nxt;
  logic              res_last_r, res_last_nxt;
  status_t           res_status_r, res_status_nxt;

  prime_t            out_value_r;
  pos_t              out_pos_r;
  logic              out_last_r;
  status_t           out_status_r;

  logic              slot_free;
  logic              load_out;
  logic              rem_start;
  rem_stat_t         rem_stat;
  count_t            want_clamped;
  logic [CandW-1:0]  cand_plus;

  psd_rem #(
    .NUM_W (VALUE_WIDTH),
    .DIV_W (DivW)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .num   (cand_r[VALUE_WIDTH-1:0]),
    .div   (d_r),
    .stat  (rem_stat)
  );

  // Zero asks for one prime; anything above MAX_COUNT saturates.
  always_comb begin
    if (cfg_r == '0) begin
      want_clamped = count_t'(1);
    end else if (cfg_r > MaxCnt) begin
      want_clamped = MaxCnt;
    end else begin
      want_clamped = cfg_r;
    end
  end

  assign cand_plus = cand_r + CandW'(CAND_STEP);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cfg_nxt   = cfg_wr_en ? cfg_wr_data : cfg_r;

  // Search sequencer.
  always_comb begin
    state_nxt      = state_r;
    five_nxt       = five_r;
    cand_nxt       = cand_r;
    d_nxt          = d_r;
    sq_nxt         = sq_r;
    found_nxt      = found_r;
    want_nxt       = want_r;
    res_value_nxt  = res_value_r;
    res_pos_nxt    = res_pos_r;
    res_last_nxt   = res_last_r;
    res_status_nxt = res_status_r;
    rem_start      = 1'b0;
    load_out       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          want_nxt  = want_clamped;
          found_nxt = '0;
          five_nxt  = 1'b0;
          cand_nxt  = CandW'(in_ch.last_digit);
          if ((in_ch.last_digit > DIGIT_MAX) || !in_ch.last_digit[0]) begin
            // Even or out-of-range digit: one reject result ends the run.
            res_value_nxt  = '0;
            res_pos_nxt    = '0;
            res_last_nxt   = 1'b1;
            res_status_nxt = ST_REJECT;
            state_nxt      = S_EMIT;
          end else if (in_ch.last_digit == DIGIT_FIVE) begin
            // Five is the only prime ending in 5; exhausted follows if more wanted.
            res_value_nxt  = prime_t'(DIGIT_FIVE);
            res_pos_nxt    = '0;
            res_last_nxt   = (want_clamped == count_t'(1));
            res_status_nxt = ST_OK;
            five_nxt       = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_CAND;
          end
        end
      end

      S_CAND: begin
        if (cand_r[VALUE_WIDTH]) begin
          // Candidate ran past the value range.
          res_value_nxt  = '0;
          res_pos_nxt    = pos_t'(found_r);
          res_last_nxt   = 1'b1;
          res_status_nxt = ST_LIMIT;
          state_nxt      = S_EMIT;
        end else if (cand_r <= CandW'(1)) begin
          cand_nxt = cand_plus;
        end else begin
          d_nxt     = DivW'(FIRST_DIVISOR);
          sq_nxt    = SqW'(FIRST_DIVISOR * FIRST_DIVISOR);
          state_nxt = S_DCHK;
        end
      end

      S_DCHK: begin
        if (sq_r > SqW'(cand_r)) begin
          // No divisor up to the square root: prime.
          res_value_nxt  = prime_t'(cand_r);
          res_pos_nxt    = pos_t'(found_r);
          res_last_nxt   = (count_t'(found_r + 1'b1) == want_r);
          res_status_nxt = ST_OK;
          found_nxt      = count_t'(found_r + 1'b1);
          state_nxt      = S_EMIT;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.is_zero) begin
            // Divisor found: drop the candidate.
            cand_nxt  = cand_plus;
            state_nxt = S_CAND;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            d_nxt     = DivW'(d_r + 1'b1);
            sq_nxt    = sq_r + SqW'({d_r, 1'b1});
            state_nxt = S_DCHK;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else if (five_r) begin
            res_value_nxt  = '0;
            res_pos_nxt    = pos_t'(1);
            res_last_nxt   = 1'b1;
            res_status_nxt = ST_EXHAUSTED;
            five_nxt       = 1'b0;
          end else begin
            cand_nxt  = cand_plus;
            state_nxt = S_CAND;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: hold until transferred, reload from the pending result.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= PRIME_COUNT_RST;
      five_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      five_r      <= five_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    d_r          <= d_nxt;
    sq_r         <= sq_nxt;
    found_r      <= found_nxt;
    want_r       <= want_nxt;
    res_value_r  <= res_value_nxt;
    res_pos_r    <= res_pos_nxt;
    res_last_r   <= res_last_nxt;
    res_status_r <= res_status_nxt;
    if (load_out) begin
      out_value_r  <= res_value_r;
      out_pos_r    <= res_pos_r;
      out_last_r   <= res_last_r;
      out_status_r <= res_status_r;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.prime_value = out_value_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.status      = out_status_r;

endmodule

>>> src/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the prime search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psd_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              out_valid,
  input  logic              out_ready,
  input  psd_pkg::prime_t   out_value,
  input  psd_pkg::pos_t     out_position,
  input  logic              out_last,
  input  psd_pkg::status_t  out_status
);
  import psd_pkg::*;

  // A result waits until its transfer.
  `PSD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  // An accepted request keeps the block busy in the next cycle.
  `PSD_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // Between runs only a final result may still wait.
  `PSD_ASSERT(a_idle_no_open_run, clk, rst_n, in_ready |-> !(out_valid && !out_last))

  // A reject is a lone, empty result.
  `PSD_ASSERT(a_reject_shape, clk, rst_n, out_valid && out_status == ST_REJECT |-> out_last && out_position == '0 && out_value == '0)

  // Reset leaves the block ready with nothing to send.
  `PSD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> in_ready && !out_valid)

endmodule

bind prime_search_by_last_digit psd_checker u_psd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.prime_value),
  .out_position (out_ch.position),
  .out_last     (out_ch.last_of_run),
  .out_status   (out_ch.status)
);
